/* rtl/assert_macros.svh */
// Assertion macros shared by the reassembler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, ignored while reset is asserted.
`define CRM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define CRM_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CRM_ASSERT(name, clk, rstn, prop, msg)
`define CRM_ASSERT_NR(name, clk, prop, msg)

`endif

`endif

/* rtl/crm_pkg.sv */
// Shared status codes and controller/datapath interface types.
`timescale 1ns / 1ps

package crm_pkg;

    localparam logic [2:0] ST_SINGLE    = 3'd0;
    localparam logic [2:0] ST_ASSEMBLED = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_MISSING   = 3'd4;
    localparam logic [2:0] ST_MISMATCH  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;

    typedef struct packed {
        logic       in_ready;
        logic       decide;
        logic       commit;
        logic       clear_store;
        logic       copy_rd;
        logic       copy_wr;
        logic       start_single;
        logic       start_asm;
        logic       rd_len;
        logic       rd_byte;
        logic       src_store;
        logic       load_byte;
        logic       load_status;
        logic       advance;
        logic [2:0] status_code;
    } cmd_t;

    typedef struct packed {
        logic short_chunk;
        logic over;
        logic single_ok;
        logic id_oob;
        logic dup;
        logic id_zero;
        logic copy_done;
        logic complete;
        logic too_long;
        logic mismatch;
        logic chunk_done;
        logic msg_done;
        logic out_valid;
        logic out_taken;
        logic out_last;
    } sts_t;

endpackage

/* rtl/crm_dp.sv */
// Datapath: staging buffer, chunk store, bookkeeping registers and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crm_dp
    import crm_pkg::*;
#(
    parameter int MAX_CHUNK_BYTES = 20,
    parameter int MAX_CHUNKS      = 16,
    parameter int MAX_MESSAGE     = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic       s_axis_tvalid,
    input  logic [7:0] s_axis_tdata,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic [3:0] m_axis_tuser,
    output logic       m_axis_tlast
);

    localparam int SAW   = $clog2(MAX_CHUNK_BYTES);
    localparam int SBW   = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int IDW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int DEPTH = MAX_CHUNKS * MAX_CHUNK_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int TSW   = $clog2(DEPTH + 1);
    localparam int TW    = (TSW > 8) ? TSW : 8;
    localparam int KMAX  = (MAX_MESSAGE > MAX_CHUNK_BYTES) ? MAX_MESSAGE : MAX_CHUNK_BYTES;
    localparam int KW    = $clog2(KMAX + 1);

    logic [7:0]            stg_mem   [MAX_CHUNK_BYTES];
    logic [7:0]            store_mem [DEPTH];
    logic [SAW-1:0]        len_mem   [MAX_CHUNKS];

    logic [SBW-1:0]        cnt_reg;
    logic                  over_reg;
    logic [7:0]            id_reg;
    logic [7:0]            b1_reg;
    logic [SAW-1:0]        plen_reg;
    logic [MAX_CHUNKS-1:0] mask_reg;
    logic [IDW-1:0]        highest_reg;
    logic [TW-1:0]         total_reg;
    logic [7:0]            first0_reg;
    logic [SAW-1:0]        j_reg;
    logic [IDW-1:0]        i_reg;
    logic [KW-1:0]         k_reg;
    logic [KW-1:0]         target_reg;
    logic [AW-1:0]         base_reg;
    logic [7:0]            stg_rdata_reg;
    logic [7:0]            store_rdata_reg;
    logic [SAW-1:0]        len_rdata_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_bv_reg;
    logic                  out_last_reg;
    logic [2:0]            out_status_reg;

    logic                  in_fire;
    logic                  out_taken;
    logic                  stg_has_room;
    logic [SBW-1:0]        cnt_minus1;
    logic [SAW-1:0]        plen_now;
    logic [IDW-1:0]        id_idx;
    logic [MAX_CHUNKS-1:0] id_bit;
    logic [MAX_CHUNKS-1:0] mask_base;
    logic [IDW-1:0]        highest_base;
    logic [TW-1:0]         total_base;
    logic [MAX_CHUNKS:0]   low_ext;
    logic [SAW-1:0]        stg_raddr;
    logic [AW-1:0]         store_addr;

    assign in_fire      = s_axis_tvalid & cmd.in_ready;
    assign out_taken    = out_valid_reg & m_axis_tready;
    assign stg_has_room = cnt_reg < SBW'(MAX_CHUNK_BYTES);
    assign cnt_minus1   = cnt_reg - 1'b1;
    assign plen_now     = cnt_minus1[SAW-1:0];
    assign id_idx       = id_reg[IDW-1:0];
    assign id_bit       = MAX_CHUNKS'(1) << id_idx;
    assign mask_base    = cmd.clear_store ? '0 : mask_reg;
    assign highest_base = cmd.clear_store ? '0 : highest_reg;
    assign total_base   = cmd.clear_store ? '0 : total_reg;
    assign low_ext      = ((MAX_CHUNKS + 1)'(1) << ({1'b0, highest_reg} + 1'b1)) - 1'b1;
    assign stg_raddr    = j_reg + 1'b1;
    assign store_addr   = base_reg + AW'(j_reg);

    // Staging buffer: written as bytes arrive, read for copy or single delivery
    always_ff @(posedge clk)
    begin
        if (in_fire && stg_has_room)
        begin
            stg_mem[cnt_reg[SAW-1:0]] <= s_axis_tdata;
        end
        if (cmd.copy_rd || (cmd.rd_byte && !cmd.src_store))
        begin
            stg_rdata_reg <= stg_mem[stg_raddr];
        end
    end

    // Chunk store, MAX_CHUNK_BYTES slots per id
    always_ff @(posedge clk)
    begin
        if (cmd.copy_wr)
        begin
            store_mem[store_addr] <= stg_rdata_reg;
        end
        if (cmd.rd_byte && cmd.src_store)
        begin
            store_rdata_reg <= store_mem[store_addr];
        end
    end

    // Payload length per id
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            len_mem[id_idx] <= plen_now;
        end
        if (cmd.rd_len)
        begin
            len_rdata_reg <= len_mem[i_reg];
        end
    end

    // Header capture of the chunk in progress
    always_ff @(posedge clk)
    begin
        if (in_fire && cnt_reg == SBW'(0))
        begin
            id_reg <= s_axis_tdata;
        end
        if (in_fire && cnt_reg == SBW'(1))
        begin
            b1_reg <= s_axis_tdata;
        end
        if (cmd.decide)
        begin
            plen_reg <= plen_now;
        end
        if (cmd.commit && id_idx == '0)
        begin
            first0_reg <= b1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            over_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            cnt_reg  <= '0;
            over_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (stg_has_room)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                over_reg <= 1'b1;
            end
        end
    end

    // Store bookkeeping: presence mask, highest id, running payload total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            highest_reg <= '0;
            total_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            mask_reg    <= mask_base | id_bit;
            highest_reg <= (id_idx > highest_base) ? id_idx : highest_base;
            total_reg   <= total_base + TW'(plen_now);
        end
        else if (cmd.clear_store)
        begin
            mask_reg    <= '0;
            highest_reg <= '0;
            total_reg   <= '0;
        end
    end

    // Walk counters for copy and readout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg      <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            target_reg <= '0;
            base_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            j_reg    <= '0;
            base_reg <= AW'(id_idx * MAX_CHUNK_BYTES);
        end
        else if (cmd.copy_wr)
        begin
            j_reg <= j_reg + 1'b1;
        end
        else if (cmd.start_single)
        begin
            j_reg      <= '0;
            k_reg      <= '0;
            target_reg <= KW'(cnt_minus1);
        end
        else if (cmd.start_asm)
        begin
            j_reg      <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            base_reg   <= '0;
            target_reg <= KW'(total_reg);
        end
        else if (cmd.advance)
        begin
            k_reg <= k_reg + 1'b1;
            if (cmd.src_store && sts.chunk_done)
            begin
                j_reg    <= '0;
                i_reg    <= i_reg + 1'b1;
                base_reg <= base_reg + AW'(MAX_CHUNK_BYTES);
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_byte || cmd.load_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            out_byte_reg   <= cmd.src_store ? store_rdata_reg : stg_rdata_reg;
            out_bv_reg     <= 1'b1;
            out_last_reg   <= sts.msg_done;
            out_status_reg <= cmd.status_code;
        end
        else if (cmd.load_status)
        begin
            out_byte_reg   <= 8'h00;
            out_bv_reg     <= 1'b0;
            out_last_reg   <= 1'b1;
            out_status_reg <= cmd.status_code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_status_reg, out_bv_reg};
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        sts.short_chunk = cnt_reg < SBW'(2);
        sts.over        = over_reg;
        sts.single_ok   = (id_reg == 8'h00) && (b1_reg == 8'(cnt_minus1));
        sts.id_oob      = id_reg >= 8'(MAX_CHUNKS);
        sts.dup         = mask_reg[id_idx];
        sts.id_zero     = id_reg == 8'h00;
        sts.copy_done   = (j_reg + 1'b1) == plen_reg;
        sts.complete    = mask_reg == low_ext[MAX_CHUNKS-1:0];
        sts.too_long    = total_reg > TW'(MAX_MESSAGE);
        sts.mismatch    = total_reg != TW'(first0_reg);
        sts.chunk_done  = (j_reg + 1'b1) == len_rdata_reg;
        sts.msg_done    = (k_reg + 1'b1) == target_reg;
        sts.out_valid   = out_valid_reg;
        sts.out_taken   = out_taken;
        sts.out_last    = out_last_reg;
    end

    `CRM_ASSERT(a_mask_above_highest, clk, rst_n, ((mask_reg >> highest_reg) >> 1) == '0, "stored id above highest id")
    `CRM_ASSERT(a_total_empty, clk, rst_n, (mask_reg == '0) |-> (total_reg == '0), "payload total without stored chunks")
    `CRM_ASSERT(a_copy_in_range, clk, rst_n, cmd.copy_wr |-> (j_reg < plen_reg), "copy past chunk payload")

endmodule

/* rtl/crm_ctrl.sv */
// Controller: sequences receive, decision, copy, check and readout of chunks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crm_ctrl
    import crm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    input  logic s_axis_tlast,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        S_RECV    = 9'b000000001,
        S_DECIDE  = 9'b000000010,
        S_COPY_RD = 9'b000000100,
        S_COPY_WR = 9'b000001000,
        S_EVAL    = 9'b000010000,
        S_RD_LEN  = 9'b000100000,
        S_RD_BYTE = 9'b001000000,
        S_LOAD    = 9'b010000000,
        S_OUT     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   asm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RECV;
            asm_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.decide)
            begin
                asm_reg <= 1'b0;
            end
            else if (cmd.start_asm)
            begin
                asm_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_RECV:
            begin
                cmd.in_ready = 1'b1;
                if (s_axis_tvalid && s_axis_tlast)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                priority if (sts.short_chunk)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status_code = ST_SHORT;
                    state_next      = S_OUT;
                end
                else if (sts.over)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status_code = ST_OVERFLOW;
                    state_next      = S_OUT;
                end
                else if (sts.single_ok)
                begin
                    cmd.start_single = 1'b1;
                    state_next       = S_RD_BYTE;
                end
                else if (sts.id_oob)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status_code = ST_OVERFLOW;
                    state_next      = S_OUT;
                end
                else if (sts.dup && !sts.id_zero)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status_code = ST_DUP;
                    state_next      = S_OUT;
                end
                else
                begin
                    // a repeated id 0 restarts the store
                    cmd.commit      = 1'b1;
                    cmd.clear_store = sts.dup;
                    state_next      = S_COPY_RD;
                end
            end
            S_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                state_next  = sts.copy_done ? S_EVAL : S_COPY_RD;
            end
            S_EVAL:
            begin
                priority if (!sts.complete)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status_code = ST_MISSING;
                    state_next      = S_OUT;
                end
                else if (sts.too_long)
                begin
                    cmd.clear_store = 1'b1;
                    cmd.load_status = 1'b1;
                    cmd.status_code = ST_OVERFLOW;
                    state_next      = S_OUT;
                end
                else if (sts.mismatch)
                begin
                    cmd.load_status = 1'b1;
                    cmd.status_code = ST_MISMATCH;
                    state_next      = S_OUT;
                end
                else
                begin
                    cmd.start_asm = 1'b1;
                    state_next    = S_RD_LEN;
                end
            end
            S_RD_LEN:
            begin
                cmd.rd_len = 1'b1;
                state_next = S_RD_BYTE;
            end
            S_RD_BYTE:
            begin
                cmd.rd_byte   = 1'b1;
                cmd.src_store = asm_reg;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_byte   = 1'b1;
                cmd.src_store   = asm_reg;
                cmd.status_code = asm_reg ? ST_ASSEMBLED : ST_SINGLE;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                cmd.src_store = asm_reg;
                if (sts.out_taken)
                begin
                    if (sts.out_last)
                    begin
                        // drop the store once an assembled message has gone out
                        cmd.clear_store = asm_reg;
                        state_next      = S_RECV;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = (asm_reg && sts.chunk_done) ? S_RD_LEN : S_RD_BYTE;
                    end
                end
            end
            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    `CRM_ASSERT_NR(a_reset_idle, clk, !rst_n |=> (state_reg == S_RECV), "controller not idle in reset")
    `CRM_ASSERT(a_load_when_empty, clk, rst_n, (cmd.load_byte || cmd.load_status) |-> !sts.out_valid, "result loaded over a pending transfer")
    `CRM_ASSERT(a_no_accept_busy, clk, rst_n, sts.out_valid |-> !cmd.in_ready, "input taken while a result is pending")
    `CRM_ASSERT(a_return_idle, clk, rst_n, (state_reg == S_OUT && sts.out_taken && sts.out_last) |=> (state_reg == S_RECV), "no return to receive after final transfer")

endmodule

/* rtl/chunk_message_reassembler_core.sv */
// Chunk message reassembler: top level joining controller and datapath.
// Input bytes: one transfer per cycle while idle; the closing byte starts a sequence.
// Status-only result: set at the decision on the closing byte, or once the chunk is stored.
// Message bytes: each is read, loaded into the output register and transferred before the next
// is read; an assembled message also reads each chunk's length before its first byte.
// Reset (rst_n low, asynchronous) empties the store and the chunk in progress.
`timescale 1ns / 1ps

module chunk_message_reassembler_core
    import crm_pkg::*;
#(
    parameter int MAX_CHUNK_BYTES = 20,
    parameter int MAX_CHUNKS      = 16,
    parameter int MAX_MESSAGE     = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] chunk_byte
    input  logic       s_axis_tlast,   // chunk_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] message_byte
    output logic [3:0] m_axis_tuser,   // [0] byte_valid, [3:1] status
    output logic       m_axis_tlast    // message_last
);

    cmd_t cmd;
    sts_t sts;

    crm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .sts           (sts),
        .cmd           (cmd)
    );

    crm_dp #(
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
        .MAX_CHUNKS      (MAX_CHUNKS),
        .MAX_MESSAGE     (MAX_MESSAGE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule
